// File: src/rep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RESP element parser package
// Shared codes and types for the front classifier and the back executor.
// ----------------------------------------------------------------------------
package rep_pkg;

  localparam logic [1:0] RK_PAYLOAD  = 2'd0;
  localparam logic [1:0] RK_COMPLETE = 2'd1;
  localparam logic [1:0] RK_ERROR    = 2'd2;

  localparam logic [2:0] K_STR    = 3'd0;
  localparam logic [2:0] K_ERR    = 3'd1;
  localparam logic [2:0] K_INT    = 3'd2;
  localparam logic [2:0] K_BULK   = 3'd3;
  localparam logic [2:0] K_NIL    = 3'd4;
  localparam logic [2:0] K_ARRAY  = 3'd5;
  localparam logic [2:0] K_ATTRIB = 3'd6;
  localparam logic [2:0] K_NULL   = 3'd7;

  localparam logic EC_INVALID  = 1'b0;
  localparam logic EC_OVERSIZE = 1'b1;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [0:0] ADDR_STR_LIMIT  = 1'b0;
  localparam logic [0:0] ADDR_BULK_LIMIT = 1'b1;

  // Byte class computed by the front part.
  typedef enum logic [3:0] {
    BC_OTHER = 4'd0,
    BC_DIGIT = 4'd1,
    BC_CR    = 4'd2,
    BC_LF    = 4'd3,
    BC_PLUS  = 4'd4,
    BC_MINUS = 4'd5,
    BC_COLON = 4'd6,
    BC_DOLLAR = 4'd7,
    BC_STAR  = 4'd8,
    BC_PIPE  = 4'd9,
    BC_UNDER = 4'd10
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
    logic [3:0]  digit;
  } token_t;

  typedef enum logic [10:0] {
    PH_IDLE       = 11'b00000000001,
    PH_STR        = 11'b00000000010,
    PH_STR_LF     = 11'b00000000100,
    PH_INT_SIGN   = 11'b00000001000,
    PH_INT_DIGITS = 11'b00000010000,
    PH_INT_LF     = 11'b00000100000,
    PH_BULK_DATA  = 11'b00001000000,
    PH_BULK_CR    = 11'b00010000000,
    PH_BULK_LF    = 11'b00100000000,
    PH_NULL_CR    = 11'b01000000000,
    PH_NULL_LF    = 11'b10000000000
  } phase_t;

endpackage
`default_nettype wire

// File: src/resp_element_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RESP element parser core
// Parses a RESP byte stream into payload, completion and error beats.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the queue has room. A front stage
// classifies each byte into a two-entry queue and a back state machine
// consumes one queued byte per cycle unless a result beat is stalled,
// producing at most one result beat through a single output register.
// Throughput stays at one byte per cycle while the result side takes beats
// every cycle. The number check multiplies the accumulated magnitude by ten
// and compares it exactly against the element's range in the back stage.
module resp_element_parser_core #(
  parameter int LENGTH_WIDTH = 30
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_rx_byte,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  out_result_kind,
  output logic [2:0]                  out_element_kind,
  output logic [7:0]                  out_payload_byte,
  output logic signed [63:0]          out_int_value,
  output logic [LENGTH_WIDTH-1:0]     out_string_length,
  output logic                        out_error_code,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:2]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [7:0]       str_limit_r;
  logic [29:0]      bulk_limit_r;
  logic             tok_valid, tok_ready;
  rep_pkg::token_t  tok;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      str_limit_r  <= 8'd255;
      bulk_limit_r <= 30'd536870912;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == rep_pkg::ADDR_STR_LIMIT) begin
        str_limit_r <= pwdata[7:0];
      end else begin
        bulk_limit_r <= pwdata[29:0];
      end
    end
  end

  assign prdata = (paddr[2] == rep_pkg::ADDR_BULK_LIMIT) ? {2'd0, bulk_limit_r} :
                                                           {24'd0, str_limit_r};

  rep_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .tok_valid(tok_valid), .tok_ready(tok_ready), .tok(tok)
  );

  rep_back #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .tok_valid(tok_valid), .tok_ready(tok_ready), .tok(tok),
    .str_limit(str_limit_r), .bulk_limit(bulk_limit_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_kind(out_result_kind), .out_element_kind(out_element_kind),
    .out_payload_byte(out_payload_byte), .out_int_value(out_int_value),
    .out_string_length(out_string_length), .out_error_code(out_error_code)
  );

endmodule
`default_nettype wire

// File: src/rep_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RESP front classifier
// Accepts stream bytes, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rep_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_rx_byte,
  output logic                 tok_valid,
  input  wire logic            tok_ready,
  output rep_pkg::token_t      tok
);

  rep_pkg::token_t     q_r [2];
  logic                wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  rep_pkg::token_t     cls_tok;
  logic                push, pop;

  always_comb begin
    cls_tok.data  = in_rx_byte;
    cls_tok.digit = in_rx_byte[3:0];
    if (in_rx_byte >= 8'h30 && in_rx_byte <= 8'h39) begin
      cls_tok.cls = rep_pkg::BC_DIGIT;
    end else begin
      case (in_rx_byte)
        rep_pkg::CH_CR:     cls_tok.cls = rep_pkg::BC_CR;
        rep_pkg::CH_LF:     cls_tok.cls = rep_pkg::BC_LF;
        rep_pkg::CH_PLUS:   cls_tok.cls = rep_pkg::BC_PLUS;
        rep_pkg::CH_MINUS:  cls_tok.cls = rep_pkg::BC_MINUS;
        rep_pkg::CH_COLON:  cls_tok.cls = rep_pkg::BC_COLON;
        rep_pkg::CH_DOLLAR: cls_tok.cls = rep_pkg::BC_DOLLAR;
        rep_pkg::CH_STAR:   cls_tok.cls = rep_pkg::BC_STAR;
        rep_pkg::CH_PIPE:   cls_tok.cls = rep_pkg::BC_PIPE;
        rep_pkg::CH_UNDER:  cls_tok.cls = rep_pkg::BC_UNDER;
        default:            cls_tok.cls = rep_pkg::BC_OTHER;
      endcase
    end
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign tok_valid = (cnt_r != 2'd0);
  assign tok       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = tok_valid && tok_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls_tok;
    end
  end

endmodule
`default_nettype wire

// File: src/rep_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RESP back executor
// Runs the element state machine on classified bytes and registers results.
// ----------------------------------------------------------------------------
module rep_back #(
  parameter int LENGTH_WIDTH = 30
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    tok_valid,
  output logic                         tok_ready,
  input  wire rep_pkg::token_t         tok,
  input  wire logic [7:0]              str_limit,
  input  wire logic [29:0]             bulk_limit,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_result_kind,
  output logic [2:0]                   out_element_kind,
  output logic [7:0]                   out_payload_byte,
  output logic signed [63:0]           out_int_value,
  output logic [LENGTH_WIDTH-1:0]      out_string_length,
  output logic                         out_error_code
);

  localparam logic [63:0] LMASK64 = (LENGTH_WIDTH >= 64) ? '1 :
                                     ((64'd1 << LENGTH_WIDTH) - 64'd1);

  rep_pkg::phase_t          ph_r, ph_nxt;
  logic [2:0]               kind_r, kind_nxt;
  logic                     neg_r, neg_nxt;
  logic [63:0]              acc_r, acc_nxt;
  logic                     seen_r, seen_nxt;
  logic [LENGTH_WIDTH-1:0]  len_r, len_nxt;
  logic [LENGTH_WIDTH-1:0]  rem_r, rem_nxt;

  logic                     ov_r, ov_nxt;
  logic [1:0]               rk_r, rk_nxt;
  logic [2:0]               ek_r, ek_nxt;
  logic [7:0]               pb_r, pb_nxt;
  logic [63:0]              iv_r, iv_nxt;
  logic [LENGTH_WIDTH-1:0]  sl_r, sl_nxt;
  logic                     ec_r, ec_nxt;

  logic                     step;
  logic                     emit;
  logic [63:0]              maxm;
  logic                     neg_eff;
  logic [63:0]              lim_bulk;
  logic [67:0]              acc10;
  logic                     fits;
  logic [8:0]               len_inc;

  // One byte is taken when the output stage is free or being drained.
  assign tok_ready = !ov_r || out_ready;
  assign step      = tok_valid && tok_ready;

  always_comb begin
    lim_bulk = {34'd0, bulk_limit} & LMASK64;
    neg_eff  = neg_r;
    case (kind_r)
      rep_pkg::K_INT:   maxm = neg_eff ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
      rep_pkg::K_BULK:  maxm = neg_eff ? 64'd1 : lim_bulk;
      rep_pkg::K_ARRAY: maxm = neg_eff ? 64'd1 : 64'hFFFFFFFF;
      default:          maxm = neg_eff ? 64'd0 : 64'h7FFFFFFF;
    endcase
    // The new magnitude is compared exactly at full width.
    acc10 = {4'd0, acc_r} * 68'd10 + {64'd0, tok.digit};
    fits  = (acc10 <= {4'd0, maxm});
    len_inc = {1'b0, len_r[((LENGTH_WIDTH < 8) ? LENGTH_WIDTH : 8)-1:0]} + 9'd1;
  end

  always_comb begin
    ph_nxt   = ph_r;
    kind_nxt = kind_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    seen_nxt = seen_r;
    len_nxt  = len_r;
    rem_nxt  = rem_r;
    emit     = 1'b0;
    rk_nxt   = rep_pkg::RK_ERROR;
    ek_nxt   = kind_r;
    pb_nxt   = 8'd0;
    iv_nxt   = 64'd0;
    sl_nxt   = '0;
    ec_nxt   = rep_pkg::EC_INVALID;

    case (ph_r)
      rep_pkg::PH_IDLE: begin
        neg_nxt  = 1'b0;
        acc_nxt  = 64'd0;
        seen_nxt = 1'b0;
        len_nxt  = '0;
        rem_nxt  = '0;
        case (tok.cls)
          rep_pkg::BC_PLUS:   begin kind_nxt = rep_pkg::K_STR;    ph_nxt = rep_pkg::PH_STR; end
          rep_pkg::BC_MINUS:  begin kind_nxt = rep_pkg::K_ERR;    ph_nxt = rep_pkg::PH_STR; end
          rep_pkg::BC_COLON:  begin kind_nxt = rep_pkg::K_INT;    ph_nxt = rep_pkg::PH_INT_SIGN; end
          rep_pkg::BC_DOLLAR: begin kind_nxt = rep_pkg::K_BULK;   ph_nxt = rep_pkg::PH_INT_SIGN; end
          rep_pkg::BC_STAR:   begin kind_nxt = rep_pkg::K_ARRAY;  ph_nxt = rep_pkg::PH_INT_SIGN; end
          rep_pkg::BC_PIPE:   begin kind_nxt = rep_pkg::K_ATTRIB; ph_nxt = rep_pkg::PH_INT_SIGN; end
          rep_pkg::BC_UNDER:  begin kind_nxt = rep_pkg::K_NULL;   ph_nxt = rep_pkg::PH_NULL_CR; end
          default: begin
            emit   = 1'b1;
            ek_nxt = rep_pkg::K_STR;
          end
        endcase
      end
      rep_pkg::PH_STR: begin
        if (tok.cls == rep_pkg::BC_CR) begin
          ph_nxt = rep_pkg::PH_STR_LF;
        end else if ((len_r > LENGTH_WIDTH'(8'hFF)) ||
                     (len_inc > {1'b0, str_limit})) begin
          emit   = 1'b1;
          ec_nxt = rep_pkg::EC_OVERSIZE;
          ph_nxt = rep_pkg::PH_IDLE;
        end else begin
          len_nxt = len_r + 1'b1;
          emit    = 1'b1;
          rk_nxt  = rep_pkg::RK_PAYLOAD;
          pb_nxt  = tok.data;
        end
      end
      rep_pkg::PH_STR_LF: begin
        emit   = 1'b1;
        ph_nxt = rep_pkg::PH_IDLE;
        if (tok.cls == rep_pkg::BC_LF) begin
          rk_nxt = rep_pkg::RK_COMPLETE;
          sl_nxt = len_r;
        end
      end
      rep_pkg::PH_INT_SIGN, rep_pkg::PH_INT_DIGITS: begin
        if (ph_r == rep_pkg::PH_INT_SIGN &&
            (tok.cls == rep_pkg::BC_PLUS || tok.cls == rep_pkg::BC_MINUS)) begin
          neg_nxt = (tok.cls == rep_pkg::BC_MINUS);
          ph_nxt  = rep_pkg::PH_INT_DIGITS;
        end else if (tok.cls == rep_pkg::BC_DIGIT) begin
          if (fits) begin
            acc_nxt  = acc10[63:0];
            seen_nxt = 1'b1;
            ph_nxt   = rep_pkg::PH_INT_DIGITS;
          end else begin
            emit   = 1'b1;
            ph_nxt = rep_pkg::PH_IDLE;
          end
        end else if (ph_r == rep_pkg::PH_INT_DIGITS && tok.cls == rep_pkg::BC_CR &&
                     seen_r) begin
          ph_nxt = rep_pkg::PH_INT_LF;
        end else begin
          emit   = 1'b1;
          ph_nxt = rep_pkg::PH_IDLE;
        end
      end
      rep_pkg::PH_INT_LF: begin
        ph_nxt = rep_pkg::PH_IDLE;
        if (tok.cls != rep_pkg::BC_LF) begin
          emit = 1'b1;
        end else if (kind_r == rep_pkg::K_BULK) begin
          if (neg_r && acc_r != 64'd0) begin
            emit   = 1'b1;
            rk_nxt = rep_pkg::RK_COMPLETE;
            ek_nxt = rep_pkg::K_NIL;
            iv_nxt = '1;
          end else begin
            len_nxt = acc_r[LENGTH_WIDTH-1:0];
            rem_nxt = acc_r[LENGTH_WIDTH-1:0];
            ph_nxt  = (acc_r[LENGTH_WIDTH-1:0] == '0) ? rep_pkg::PH_BULK_CR :
                                                        rep_pkg::PH_BULK_DATA;
          end
        end else if (kind_r == rep_pkg::K_ATTRIB && (neg_r || acc_r == 64'd0)) begin
          emit = 1'b1;
        end else begin
          emit   = 1'b1;
          rk_nxt = rep_pkg::RK_COMPLETE;
          iv_nxt = neg_r ? (64'd0 - acc_r) : acc_r;
        end
      end
      rep_pkg::PH_BULK_DATA: begin
        rem_nxt = rem_r - 1'b1;
        if (rem_r == LENGTH_WIDTH'(1)) begin
          ph_nxt = rep_pkg::PH_BULK_CR;
        end
        emit   = 1'b1;
        rk_nxt = rep_pkg::RK_PAYLOAD;
        ek_nxt = rep_pkg::K_BULK;
        pb_nxt = tok.data;
      end
      rep_pkg::PH_BULK_CR: begin
        ek_nxt = rep_pkg::K_BULK;
        if (tok.cls == rep_pkg::BC_CR) begin
          ph_nxt = rep_pkg::PH_BULK_LF;
        end else begin
          emit   = 1'b1;
          ph_nxt = rep_pkg::PH_IDLE;
        end
      end
      rep_pkg::PH_BULK_LF: begin
        emit   = 1'b1;
        ek_nxt = rep_pkg::K_BULK;
        ph_nxt = rep_pkg::PH_IDLE;
        if (tok.cls == rep_pkg::BC_LF) begin
          rk_nxt = rep_pkg::RK_COMPLETE;
          sl_nxt = len_r;
        end
      end
      rep_pkg::PH_NULL_CR: begin
        ek_nxt = rep_pkg::K_NULL;
        if (tok.cls == rep_pkg::BC_CR) begin
          ph_nxt = rep_pkg::PH_NULL_LF;
        end else begin
          emit   = 1'b1;
          ph_nxt = rep_pkg::PH_IDLE;
        end
      end
      rep_pkg::PH_NULL_LF: begin
        emit   = 1'b1;
        ek_nxt = rep_pkg::K_NULL;
        ph_nxt = rep_pkg::PH_IDLE;
        if (tok.cls == rep_pkg::BC_LF) begin
          rk_nxt = rep_pkg::RK_COMPLETE;
        end
      end
      default: begin
        emit   = 1'b1;
        ph_nxt = rep_pkg::PH_IDLE;
      end
    endcase

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
    if (step && emit) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= rep_pkg::PH_IDLE;
      kind_r <= 3'd0;
      neg_r  <= 1'b0;
      acc_r  <= 64'd0;
      seen_r <= 1'b0;
      len_r  <= '0;
      rem_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (step) begin
        ph_r   <= ph_nxt;
        kind_r <= kind_nxt;
        neg_r  <= neg_nxt;
        acc_r  <= acc_nxt;
        seen_r <= seen_nxt;
        len_r  <= len_nxt;
        rem_r  <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      rk_r <= rk_nxt;
      ek_r <= ek_nxt;
      pb_r <= pb_nxt;
      iv_r <= iv_nxt;
      sl_r <= sl_nxt;
      ec_r <= ec_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_result_kind   = rk_r;
  assign out_element_kind  = ek_r;
  assign out_payload_byte  = pb_r;
  assign out_int_value     = iv_r;
  assign out_string_length = sl_r;
  assign out_error_code    = ec_r;

endmodule
`default_nettype wire

// File: src/rep_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RESP parser port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module rep_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_result_kind,
  input wire logic [63:0] out_int_value,
  input wire logic        out_error_code,
  input wire logic        pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind))
    else $error("result beat dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind <= rep_pkg::RK_ERROR)
    else $error("undefined result kind");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != rep_pkg::RK_ERROR |-> !out_error_code)
    else $error("error code set on non-error beat");

  a_pay_iv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == rep_pkg::RK_PAYLOAD |-> out_int_value == 64'd0)
    else $error("payload beat carries a value");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind resp_element_parser_core rep_checker u_rep_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_result_kind(out_result_kind), .out_int_value(out_int_value),
  .out_error_code(out_error_code), .pready(pready)
);
`default_nettype wire

// File: tb/sv/resp_element_parser_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RESP element parser core testbench
// Feeds RESP byte streams (well-formed elements, broken elements and noise)
// under random stalls, predicts every payload, completion and error beat,
// and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module resp_element_parser_core_test;

  localparam int LW = 30;
  localparam int IDLE_LIMIT = 10000;

  typedef struct packed {
    logic [1:0]    rk;
    logic [2:0]    ek;
    logic [7:0]    pb;
    logic [63:0]   iv;
    logic [LW-1:0] sl;
    logic          ec;
  } beat_t;

  typedef enum logic [3:0] {
    P_IDLE, P_STR, P_STR_LF, P_SIGN, P_DIGITS, P_NUM_LF,
    P_BULK_DATA, P_BULK_CR, P_BULK_LF, P_NULL_CR, P_NULL_LF
  } parse_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_result_kind;
  logic [2:0] out_element_kind;
  logic [7:0] out_payload_byte;
  logic signed [63:0] out_int_value;
  logic [LW-1:0] out_string_length;
  logic out_error_code;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:2] paddr = 1'b0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;

  resp_element_parser_core #(.LENGTH_WIDTH(LW)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_kind(out_result_kind), .out_element_kind(out_element_kind),
    .out_payload_byte(out_payload_byte), .out_int_value(out_int_value),
    .out_string_length(out_string_length), .out_error_code(out_error_code),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Parser state as predicted from the accepted bytes.
  parse_state_t pst = P_IDLE;
  logic [2:0] cur_kind = rep_pkg::K_STR;
  logic neg = 1'b0;
  logic [63:0] acc = '0;
  logic [4:0] ndig = '0;
  logic [LW-1:0] str_len = '0;
  logic [LW-1:0] bulk_left = '0;
  logic [7:0] str_limit = 8'd255;
  logic [LW-1:0] bulk_limit = 30'd536870912;

  beat_t parsed_beats[$];
  logic [7:0] stream_q[$];
  logic [7:0] elem_q[$];

  logic in_hs = 1'b0;
  logic quiet = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  int fails = 0;
  int n_bytes = 0;
  int n_payload = 0;
  int n_complete = 0;
  int n_errors = 0;

  function automatic beat_t mk_beat(logic [1:0] rk, logic [2:0] ek, logic [7:0] pb,
                                    logic [63:0] iv, logic [LW-1:0] sl, logic ec);
    beat_t b;
    b.rk = rk; b.ek = ek; b.pb = pb; b.iv = iv; b.sl = sl; b.ec = ec;
    return b;
  endfunction

  function automatic logic [63:0] max_magnitude();
    case (cur_kind)
      rep_pkg::K_INT:   return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      rep_pkg::K_BULK:  return neg ? 64'd1 : {{(64-LW){1'b0}}, bulk_limit};
      rep_pkg::K_ARRAY: return neg ? 64'd1 : 64'hFFFF_FFFF;
      default:          return neg ? 64'd0 : 64'h7FFF_FFFF;
    endcase
  endfunction

  // Returns 0 when the new digit pushes the magnitude out of range.
  function automatic bit take_digit(logic [7:0] c);
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] d;
    m = max_magnitude();
    q = m / 64'd10;
    d = {56'd0, c - 8'h30};
    if (acc > q || (acc == q && d > m % 64'd10)) return 1'b0;
    acc = acc * 64'd10 + d;
    if (ndig != 5'd31) ndig = ndig + 5'd1;
    return 1'b1;
  endfunction

  task automatic parse_error(logic [2:0] ek, logic ec);
    pst = P_IDLE;
    parsed_beats.push_back(mk_beat(rep_pkg::RK_ERROR, ek, 8'd0, 64'd0, '0, ec));
  endtask

  task automatic predict_byte(logic [7:0] b);
    bit is_digit;
    is_digit = (b >= 8'h30 && b <= 8'h39);
    case (pst)
      P_IDLE: begin
        neg = 1'b0; acc = '0; ndig = '0; str_len = '0; bulk_left = '0;
        if (b == rep_pkg::CH_PLUS || b == rep_pkg::CH_MINUS) begin
          cur_kind = (b == rep_pkg::CH_PLUS) ? rep_pkg::K_STR : rep_pkg::K_ERR;
          pst = P_STR;
        end else if (b == rep_pkg::CH_COLON || b == rep_pkg::CH_DOLLAR ||
                     b == rep_pkg::CH_STAR || b == rep_pkg::CH_PIPE) begin
          cur_kind = (b == rep_pkg::CH_COLON) ? rep_pkg::K_INT :
                     (b == rep_pkg::CH_DOLLAR) ? rep_pkg::K_BULK :
                     (b == rep_pkg::CH_STAR) ? rep_pkg::K_ARRAY : rep_pkg::K_ATTRIB;
          pst = P_SIGN;
        end else if (b == rep_pkg::CH_UNDER) begin
          cur_kind = rep_pkg::K_NULL;
          pst = P_NULL_CR;
        end else begin
          parse_error(rep_pkg::K_STR, rep_pkg::EC_INVALID);
        end
      end
      P_STR: begin
        if (b == rep_pkg::CH_CR) begin
          pst = P_STR_LF;
        end else if ({1'b0, str_len} + 1 > {{(LW-7){1'b0}}, str_limit}) begin
          parse_error(cur_kind, rep_pkg::EC_OVERSIZE);
        end else begin
          str_len = str_len + 1'b1;
          parsed_beats.push_back(mk_beat(rep_pkg::RK_PAYLOAD, cur_kind, b, 64'd0, '0,
                                         1'b0));
        end
      end
      P_STR_LF: begin
        if (b != rep_pkg::CH_LF) begin
          parse_error(cur_kind, rep_pkg::EC_INVALID);
        end else begin
          pst = P_IDLE;
          parsed_beats.push_back(mk_beat(rep_pkg::RK_COMPLETE, cur_kind, 8'd0, 64'd0,
                                         str_len, 1'b0));
        end
      end
      P_SIGN: begin
        if (b == rep_pkg::CH_MINUS || b == rep_pkg::CH_PLUS) begin
          neg = (b == rep_pkg::CH_MINUS);
          pst = P_DIGITS;
        end else if (!is_digit) begin
          parse_error(cur_kind, rep_pkg::EC_INVALID);
        end else begin
          pst = P_DIGITS;
          if (!take_digit(b)) parse_error(cur_kind, rep_pkg::EC_INVALID);
        end
      end
      P_DIGITS: begin
        if (is_digit) begin
          if (!take_digit(b)) parse_error(cur_kind, rep_pkg::EC_INVALID);
        end else if (b == rep_pkg::CH_CR && ndig != 0) begin
          pst = P_NUM_LF;
        end else begin
          parse_error(cur_kind, rep_pkg::EC_INVALID);
        end
      end
      P_NUM_LF: begin
        if (b != rep_pkg::CH_LF) begin
          parse_error(cur_kind, rep_pkg::EC_INVALID);
        end else begin
          pst = P_IDLE;
          if (cur_kind == rep_pkg::K_BULK) begin
            if (neg && acc != 0) begin
              parsed_beats.push_back(mk_beat(rep_pkg::RK_COMPLETE, rep_pkg::K_NIL, 8'd0,
                                             '1, '0, 1'b0));
            end else begin
              str_len = acc[LW-1:0];
              bulk_left = str_len;
              pst = (str_len == 0) ? P_BULK_CR : P_BULK_DATA;
            end
          end else if (cur_kind == rep_pkg::K_ATTRIB && (neg || acc == 0)) begin
            parse_error(cur_kind, rep_pkg::EC_INVALID);
          end else begin
            parsed_beats.push_back(mk_beat(rep_pkg::RK_COMPLETE, cur_kind, 8'd0,
                                           neg ? 64'd0 - acc : acc, '0, 1'b0));
          end
        end
      end
      P_BULK_DATA: begin
        bulk_left = bulk_left - 1'b1;
        if (bulk_left == 0) pst = P_BULK_CR;
        parsed_beats.push_back(mk_beat(rep_pkg::RK_PAYLOAD, rep_pkg::K_BULK, b, 64'd0,
                                       '0, 1'b0));
      end
      P_BULK_CR, P_NULL_CR: begin
        if (b != rep_pkg::CH_CR) begin
          parse_error(pst == P_BULK_CR ? rep_pkg::K_BULK : rep_pkg::K_NULL,
                      rep_pkg::EC_INVALID);
        end else begin
          pst = (pst == P_BULK_CR) ? P_BULK_LF : P_NULL_LF;
        end
      end
      P_BULK_LF: begin
        if (b != rep_pkg::CH_LF) begin
          parse_error(rep_pkg::K_BULK, rep_pkg::EC_INVALID);
        end else begin
          pst = P_IDLE;
          parsed_beats.push_back(mk_beat(rep_pkg::RK_COMPLETE, rep_pkg::K_BULK, 8'd0,
                                         64'd0, str_len, 1'b0));
        end
      end
      P_NULL_LF: begin
        if (b != rep_pkg::CH_LF) begin
          parse_error(rep_pkg::K_NULL, rep_pkg::EC_INVALID);
        end else begin
          pst = P_IDLE;
          parsed_beats.push_back(mk_beat(rep_pkg::RK_COMPLETE, rep_pkg::K_NULL, 8'd0,
                                         64'd0, '0, 1'b0));
        end
      end
      default: parse_error(cur_kind, rep_pkg::EC_INVALID);
    endcase
  endtask

  task automatic report_mismatch(string what, beat_t got, beat_t want);
    fails++;
    $display({"MISMATCH %s: got rk=%0d ek=%0d pb=%h iv=%h sl=%0d ec=%0d,",
              " want rk=%0d ek=%0d pb=%h iv=%h sl=%0d ec=%0d"},
             what, got.rk, got.ek, got.pb, got.iv, got.sl, got.ec,
             want.rk, want.ek, want.pb, want.iv, want.sl, want.ec);
  endtask

  // Result monitor, byte predictor and watchdog.
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    in_hs <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      got = mk_beat(out_result_kind, out_element_kind, out_payload_byte,
                    out_int_value, out_string_length, out_error_code);
      if (got.rk == rep_pkg::RK_PAYLOAD) n_payload++;
      else if (got.rk == rep_pkg::RK_COMPLETE) n_complete++;
      else n_errors++;
      if (parsed_beats.size() == 0) begin
        report_mismatch("unexpected beat", got, '0);
      end else begin
        want = parsed_beats.pop_front();
        if (got != want) report_mismatch("field", got, want);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      predict_byte(in_rx_byte);
      n_bytes++;
    end
    if ((rst_n && in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Byte driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_hs) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (stream_q.size() > 0) begin
      in_rx_byte <= stream_q.pop_front();
      in_valid <= 1'b1;
      if (!quiet && $urandom_range(0, 6) == 0) in_gap = $urandom_range(1, 4);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result-side stalls.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 6) == 0) out_gap = $urandom_range(1, 4);
    end
  end

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endtask

  task automatic put_line(string s);
    put_text(s);
    stream_q.push_back(rep_pkg::CH_CR);
    stream_q.push_back(rep_pkg::CH_LF);
  endtask

  // Noise never carries digits or a bulk marker, so it cannot open a long bulk body.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = $urandom_range(0, 255);
    if ((b >= 8'h30 && b <= 8'h39) || b == rep_pkg::CH_DOLLAR) b = b ^ 8'h40;
    return b;
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) elem_q.push_back(s[i]);
  endtask

  task automatic add_crlf();
    elem_q.push_back(rep_pkg::CH_CR);
    elem_q.push_back(rep_pkg::CH_LF);
  endtask

  task automatic build_element();
    int sel;
    int n;
    logic [7:0] c;
    longint v;
    elem_q.delete();
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: begin
        elem_q.push_back($urandom_range(0, 1) ? rep_pkg::CH_PLUS : rep_pkg::CH_MINUS);
        n = $urandom_range(0, str_limit < 12 ? str_limit : 12);
        if (str_limit < 20 && $urandom_range(0, 5) == 0) n = str_limit + 1;
        for (int i = 0; i < n; i++) begin
          c = noise_byte();
          if (c == rep_pkg::CH_CR) c = 8'h4D;
          elem_q.push_back(c);
        end
        add_crlf();
      end
      2, 3: begin
        v = $urandom_range(0, 1) ? longint'({$urandom, $urandom})
                                 : longint'($urandom_range(0, 999));
        if ($urandom_range(0, 3) == 0) v = -v;
        add_text(v >= 0 && $urandom_range(0, 1) ? ":+" : ":");
        add_text($sformatf("%0d", v));
        add_crlf();
      end
      4, 5: begin
        if ($urandom_range(0, 9) == 0) begin
          add_text("$-1");
          add_crlf();
        end else if (bulk_limit < 64 && $urandom_range(0, 7) == 0) begin
          add_text($sformatf("$%0d", bulk_limit + 1));
          add_crlf();
        end else begin
          n = $urandom_range(0, bulk_limit < 16 ? bulk_limit : 16);
          add_text($sformatf("$%0d", n));
          add_crlf();
          for (int i = 0; i < n; i++) elem_q.push_back($urandom_range(0, 255));
          add_crlf();
        end
      end
      6: begin
        if ($urandom_range(0, 7) == 0) add_text("*-1");
        else add_text($sformatf("*%0d", $urandom));
        add_crlf();
      end
      7: begin
        add_text($sformatf("|%0d", $urandom_range(1, 32'h7FFF_FFFF)));
        add_crlf();
      end
      8: begin
        add_text("_");
        add_crlf();
      end
      default: elem_q.push_back(noise_byte());
    endcase
  endtask

  // Mostly well-formed elements, some cut short by a stray byte, some pure noise.
  task automatic random_traffic(int target);
    int r;
    int keep;
    int start;
    start = stream_q.size() + n_bytes;
    while (stream_q.size() + n_bytes - start < target) begin
      build_element();
      r = $urandom_range(0, 9);
      if (r == 0) begin
        keep = $urandom_range(0, elem_q.size() - 1);
        for (int i = 0; i < keep; i++) stream_q.push_back(elem_q[i]);
        stream_q.push_back(noise_byte());
      end else if (r == 1) begin
        repeat ($urandom_range(1, 3)) stream_q.push_back(noise_byte());
      end else begin
        foreach (elem_q[i]) stream_q.push_back(elem_q[i]);
      end
    end
  endtask

  // Waits for every beat to drain; then nudges the parser back to idle if needed.
  task automatic settle();
    do begin
      while (stream_q.size() != 0 || in_valid || parsed_beats.size() != 0) @(posedge clk);
      repeat (8) @(posedge clk);
      if (pst != P_IDLE) stream_q.push_back(8'h00);
    end while (stream_q.size() != 0);
  endtask

  task automatic cfg_write(logic [0:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= idx; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == rep_pkg::ADDR_STR_LIMIT) str_limit = value[7:0];
    else bulk_limit = value[LW-1:0];
  endtask

  task automatic set_limits(logic [7:0] s_lim, logic [LW-1:0] b_lim);
    cfg_write(rep_pkg::ADDR_STR_LIMIT, {24'd0, s_lim});
    cfg_write(rep_pkg::ADDR_BULK_LIMIT, {{(32-LW){1'b0}}, b_lim});
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed cases at the reset limits.
    stream_q.push_back(8'h78);
    put_line(":9223372036854775807");
    put_line(":-9223372036854775808");
    put_line(":+9223372036854775808");
    put_line(":");
    put_line(":12a");
    put_line("*-1");
    put_line("*4294967295");
    put_line("*4294967296");
    put_line("|0");
    put_line("|2147483647");
    put_line("|2147483648");
    put_line("$-1");
    put_line("$-0");
    put_line("");
    put_line("$-2");
    put_line("$4");
    stream_q.push_back(rep_pkg::CH_CR); stream_q.push_back(rep_pkg::CH_LF);
    stream_q.push_back(8'hFF); stream_q.push_back(8'h00);
    put_line("");
    put_line("$0");
    put_line("");
    put_line("_");
    put_text("_x");
    put_text("+OK"); stream_q.push_back(rep_pkg::CH_CR); stream_q.push_back(8'h58);
    put_line("-ERR bad");
    random_traffic(60);
    settle();

    set_limits(8'd0, '0);
    put_line("+");
    put_line("+a");
    put_line("$0");
    put_line("");
    put_line("$1");
    random_traffic(80);
    settle();

    set_limits(8'd5, 30'd7);
    put_line("+abcde");
    put_line("-abcdef");
    put_line("$7");
    put_line("1234567");
    put_line("$8");
    random_traffic(80);
    settle();

    set_limits(8'd255, 30'h3FFF_FFFF);
    put_line("$1073741824");
    random_traffic(90);
    settle();

    set_limits($urandom_range(1, 254), $urandom_range(1, 40));
    random_traffic(100);
    settle();

    quiet = 1'b1;
    set_limits($urandom_range(0, 255), 30'h3FFF_FFFF);
    random_traffic(110);
    settle();

    $display("Parsed %0d bytes across six limit settings, %s",
             n_bytes, "including range edges and broken input.");
    $display("Beats checked: %0d payload, %0d complete, %0d error.",
             n_payload, n_complete, n_errors);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: resp_element_parser_core.f
src/rep_pkg.sv
src/rep_front.sv
src/rep_back.sv
src/resp_element_parser_core.sv
src/rep_checker.sv
tb/sv/resp_element_parser_core_test.sv
